// ===== hw/rtl/pfrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfrp_pkg;

	localparam int FREQ_W = 20;
	localparam int X_W = 23;
	localparam int RECIP_W = 18;
	localparam int PROD_W = X_W + RECIP_W;
	localparam int INT_W = 8;
	localparam int INT_FIELD_W = 16;
	localparam int KHZ_W = 18;
	localparam int WORD_W = 32;

	localparam logic [X_W-1:0] REF_KHZ = X_W'(25000);
	localparam logic [X_W-1:0] HALF_REF_KHZ = X_W'(25000 / 2);
	// floor(2^32 / 25000); the estimate is low by at most one.
	localparam logic [RECIP_W-1:0] REF_RECIP = RECIP_W'(171798);
	localparam int RECIP_SHIFT = 32;

	localparam logic [FREQ_W-1:0] BAND_MIN = FREQ_W'(35000);
	localparam logic [FREQ_W-1:0] BAND_64_PS8 = FREQ_W'(56250);
	localparam logic [FREQ_W-1:0] BAND_32_PS4 = FREQ_W'(68750);
	localparam logic [FREQ_W-1:0] BAND_32_PS8 = FREQ_W'(112500);
	localparam logic [FREQ_W-1:0] BAND_16_PS4 = FREQ_W'(137500);
	localparam logic [FREQ_W-1:0] BAND_16_PS8 = FREQ_W'(225000);
	localparam logic [FREQ_W-1:0] BAND_MAX = FREQ_W'(250000);

	localparam logic [1:0] DIV_CODE_16 = 2'd0;
	localparam logic [1:0] DIV_CODE_32 = 2'd1;
	localparam logic [1:0] DIV_CODE_64 = 2'd2;
	localparam logic [2:0] DIV_FIELD_BASE = 3'b100;
	localparam logic [2:0] DIV_SHIFT_BASE = 3'd4;

	localparam logic [WORD_W-1:0] WORD4_RESET = 32'h00E1403C;
	localparam logic [WORD_W-1:0] WORD1_RESET = 32'h000083E9;
	localparam logic [WORD_W-1:0] WORD0_RESET = 32'h00400000;

	typedef struct packed {
		logic       err;
		logic [1:0] code;
		logic       ps8;
	} band_t;

	typedef struct packed {
		band_t            band;
		logic [INT_W-1:0] intv;
		logic [KHZ_W-1:0] khz;
	} q_entry_t;

	typedef enum logic [1:0] {
		RK_ERR,
		RK_W4,
		RK_W1,
		RK_W0
	} rkind_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfrp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrp_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pfrp_pkg::FREQ_W-1:0]  freq_khz,
	input  wire logic                         q_full,
	output logic                              push,
	output pfrp_pkg::q_entry_t                push_data
);
	import pfrp_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	band_t band_d, band_s1, band_s2, band_s3;
	logic [X_W-1:0] x_d, x_s1, x_s2, x_s3;
	logic [PROD_W-1:0] prod_s2;
	logic [INT_W-1:0] q0_s3;
	logic [X_W-1:0] qm_s3;
	logic [X_W-1:0] rem;
	logic corr;
	logic [X_W-1:0] scaled;
	logic [2:0] shamt_d, shamt_s3;
	q_entry_t ent_s4;

	assign en = !v_s4 || !q_full;
	assign in_stall = !en;
	assign push = v_s4 && !q_full;
	assign push_data = ent_s4;

	always_comb begin
		band_d = '0;
		if (freq_khz < BAND_MIN || freq_khz > BAND_MAX) begin
			band_d.err = 1'b1;
		end else if (freq_khz < BAND_64_PS8) begin
			band_d.code = DIV_CODE_64;
		end else if (freq_khz < BAND_32_PS4) begin
			band_d.code = DIV_CODE_64;
			band_d.ps8 = 1'b1;
		end else if (freq_khz < BAND_32_PS8) begin
			band_d.code = DIV_CODE_32;
		end else if (freq_khz < BAND_16_PS4) begin
			band_d.code = DIV_CODE_32;
			band_d.ps8 = 1'b1;
		end else if (freq_khz < BAND_16_PS8) begin
			band_d.code = DIV_CODE_16;
		end else begin
			band_d.code = DIV_CODE_16;
			band_d.ps8 = 1'b1;
		end
	end

	assign shamt_d = DIV_SHIFT_BASE + {1'b0, band_d.code};
	assign x_d = X_W'({{(X_W + 6 - FREQ_W){1'b0}}, freq_khz} << shamt_d) + HALF_REF_KHZ;

	assign shamt_s3 = DIV_SHIFT_BASE + {1'b0, band_s3.code};
	assign rem = x_s3 - qm_s3;
	assign corr = rem >= REF_KHZ;
	assign scaled = qm_s3 + (corr ? REF_KHZ : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			band_s1 <= band_d;
			x_s1 <= x_d;
			band_s2 <= band_s1;
			x_s2 <= x_s1;
			prod_s2 <= PROD_W'(x_s1) * PROD_W'(REF_RECIP);
			band_s3 <= band_s2;
			x_s3 <= x_s2;
			q0_s3 <= prod_s2[RECIP_SHIFT +: INT_W];
			qm_s3 <= X_W'(prod_s2[RECIP_SHIFT +: INT_W] * REF_KHZ);
			ent_s4.band <= band_s3;
			ent_s4.intv <= q0_s3 + INT_W'(corr);
			ent_s4.khz <= KHZ_W'(scaled >> shamt_s3);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfrp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrp_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire pfrp_pkg::q_entry_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output pfrp_pkg::q_entry_t      head,
	output logic                    nonempty
);
	import pfrp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	q_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfrp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pfrp_pkg::q_entry_t          head,
	input  wire logic                        nonempty,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pfrp_pkg::WORD_W-1:0]      reg_word,
	output logic                             is_error,
	output logic [pfrp_pkg::KHZ_W-1:0]       programmed_khz,
	output logic                             is_last
);
	import pfrp_pkg::*;

	logic [1:0] cur_code_q;
	logic cur_ps8_q;
	logic [WORD_W-1:0] word4_q, word1_q, word0_q;
	logic out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic err_q, last_q;
	logic [KHZ_W-1:0] khz_q;

	logic ld, fire;
	rkind_t kind;
	logic [WORD_W-1:0] new4, new1, new0;
	logic [WORD_W-1:0] word_d;
	logic err_d, last_d;
	logic [KHZ_W-1:0] khz_d;

	assign ld = !out_valid_q || !out_stall;
	assign fire = ld && nonempty;

	// The shadow copies update as each word goes out, so the next compare
	// on the same request moves on to the following word.
	always_comb begin
		if (head.band.err) begin
			kind = RK_ERR;
		end else if (head.band.code != cur_code_q) begin
			kind = RK_W4;
		end else if (head.band.ps8 != cur_ps8_q) begin
			kind = RK_W1;
		end else begin
			kind = RK_W0;
		end
	end

	assign new4 = {word4_q[31:23], DIV_FIELD_BASE + {1'b0, head.band.code}, word4_q[19:0]};
	assign new1 = {word1_q[31:28], head.band.ps8, word1_q[26:0]};
	assign new0 = {word0_q[31], INT_FIELD_W'(head.intv), word0_q[14:0]};

	always_comb begin
		word_d = '0;
		err_d = 1'b0;
		khz_d = '0;
		last_d = 1'b0;
		pop = 1'b0;
		case (kind)
			RK_ERR: begin
				err_d = 1'b1;
				last_d = 1'b1;
				pop = fire;
			end
			RK_W4: begin
				word_d = new4;
			end
			RK_W1: begin
				word_d = new1;
			end
			RK_W0: begin
				word_d = new0;
				khz_d = head.khz;
				last_d = 1'b1;
				pop = fire;
			end
			default: begin
				word_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_code_q <= DIV_CODE_64;
			cur_ps8_q <= 1'b0;
			word4_q <= WORD4_RESET;
			word1_q <= WORD1_RESET;
			word0_q <= WORD0_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= nonempty;
			end
			if (fire) begin
				case (kind)
					RK_W4: begin
						word4_q <= new4;
						cur_code_q <= head.band.code;
					end
					RK_W1: begin
						word1_q <= new1;
						cur_ps8_q <= head.band.ps8;
					end
					RK_W0: begin
						word0_q <= new0;
					end
					default: begin
						cur_code_q <= cur_code_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_q <= word_d;
			err_q <= err_d;
			khz_q <= khz_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign reg_word = word_q;
	assign is_error = err_q;
	assign programmed_khz = khz_q;
	assign is_last = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pll_frequency_register_planner_top.sv =====
// Channel  | Handshake            | Payload
// request  | in_valid, in_stall   | freq_khz
// result   | out_valid, out_stall | reg_word, is_error, programmed_khz, is_last
//
// A request passes a four-stage front pipeline (band select, scale, reciprocal
// multiply, rounding fix) and waits in a short queue for the back end.
// The back end sends one word per cycle from its output register while out_stall
// is low, so a request produces one to three words there.
// Reset returns the shadow words and divider/prescaler to their power-up values.
// Either side may stall; the queue lets the front keep accepting while it has room.
`timescale 1ns / 1ps
`default_nettype none

module pll_frequency_register_planner_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [pfrp_pkg::FREQ_W-1:0] freq_khz,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pfrp_pkg::WORD_W-1:0]     reg_word,
	output logic                             is_error,
	output logic [pfrp_pkg::KHZ_W-1:0]      programmed_khz,
	output logic                             is_last
);
	import pfrp_pkg::*;

	logic q_full, push, pop, nonempty;
	q_entry_t push_data, head;

	pfrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.freq_khz  (freq_khz),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	pfrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.nonempty  (nonempty)
	);

	pfrp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.nonempty       (nonempty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.reg_word       (reg_word),
		.is_error       (is_error),
		.programmed_khz (programmed_khz),
		.is_last        (is_last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/pfrp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [pfrp_pkg::FREQ_W-1:0] freq_khz,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [pfrp_pkg::WORD_W-1:0] reg_word,
	input wire logic                        is_error,
	input wire logic [pfrp_pkg::KHZ_W-1:0]  programmed_khz,
	input wire logic                        is_last
);
	import pfrp_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(freq_khz))
		else $error("Stalled request changed before it was taken.");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result valid dropped while stalled.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> is_last && reg_word == '0 && programmed_khz == '0)
		else $error("Error result is not a single zero result.");

	a_middle_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> !is_error && programmed_khz == '0)
		else $error("Intermediate result carries a frequency or an error.");

	a_khz_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> programmed_khz <= KHZ_W'(BAND_MAX))
		else $error("Programmed frequency beyond the top band.");

endmodule

bind pll_frequency_register_planner_top pfrp_checker u_chk (.*);

`default_nettype wire
